@@ rtl/core/wgm_pkg.sv @@
package wgm_pkg;

  // Pattern metacharacters
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_ANY  = 8'h3F;
  localparam logic [7:0] CHAR_ESC  = 8'h5C;

  // Configuration register indexes (byte address 8*index)
  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_MID  = 2'd1,
    REG_PAT_HIGH = 2'd2,
    REG_PAT_LEN  = 2'd3
  } reg_idx_e;

  // Per-byte verdict flags from the step unit
  typedef struct packed {
    logic early;
    logic matched;
  } wgm_flags_t;

endpackage

@@ rtl/core/wgm_step.sv @@
module wgm_step import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 24
) (
  input  logic [PATTERN_MAX-1:0][7:0] pat_i,
  input  logic [4:0]                  pat_len_i,
  input  logic [PATTERN_MAX:0]        active_i,
  input  logic                        early_i,
  input  logic [7:0]                  text_byte_i,
  output logic [PATTERN_MAX:0]        active_o,
  output wgm_flags_t                  flags_o
);

  localparam int P = PATTERN_MAX;

  logic [4:0]   lim;
  logic [P-1:0] in_len, zero_b, zhit, first_z, used, last_pos;
  logic [P-1:0] is_star, is_any, is_esc, is_lit, star_prop, gen;
  logic [P-1:0] reach_u, nxt_star, nxt_one, nxt_esc;
  logic [P:0]   used_ext, onehot_len, live, psum, carry_in, reach;

  // Saturate the length and classify every pattern byte
  always_comb begin
    lim = (pat_len_i > 5'(P)) ? 5'(P) : pat_len_i;
    for (int i = 0; i < P; i++) begin
      in_len[i]  = 5'(i) < lim;
      zero_b[i]  = pat_i[i] == 8'h00;
      is_star[i] = pat_i[i] == CHAR_STAR;
      is_any[i]  = pat_i[i] == CHAR_ANY;
      is_esc[i]  = pat_i[i] == CHAR_ESC;
      is_lit[i]  = pat_i[i] == text_byte_i;
    end
  end

  // In-use mask: positions below the first zero byte within the length
  assign zhit       = in_len & zero_b;
  assign first_z    = zhit & (~zhit + P'(1));
  assign used       = (zhit == '0) ? in_len : (first_z - P'(1));
  assign last_pos   = used & ~(used >> 1);
  assign used_ext   = {used, 1'b1};
  assign onehot_len = used_ext & ~(used_ext >> 1);
  assign live       = active_i & used_ext;

  // Star closure as a carry chain: a live star that is not last feeds the next position
  assign star_prop = is_star & (used >> 1);
  assign gen       = live[P-1:0] & star_prop;
  assign psum      = {1'b0, star_prop} + {1'b0, gen};
  assign carry_in  = psum ^ {1'b0, star_prop} ^ {1'b0, gen};
  assign reach     = live | carry_in;
  assign reach_u   = reach[P-1:0] & used;

  // Advance each reached position by its pattern byte
  assign nxt_star = reach_u & star_prop;
  assign nxt_one  = reach_u & (is_any | (is_lit & ~is_star & ~is_esc));
  assign nxt_esc  = reach_u & is_esc & (used >> 1) & (is_lit >> 1);
  assign active_o = {1'b0, nxt_star} | {nxt_one, 1'b0} | ({nxt_esc, 1'b0} << 1);

  // Early accept on a final star; verdict for an ending byte
  assign flags_o.early   = early_i | (|(reach_u & is_star & last_pos));
  assign flags_o.matched = early_i | (|(live & onehot_len))
                         | (|(live[P-1:0] & last_pos & is_star));

endmodule

@@ rtl/core/wildcard_glob_matcher.sv @@
// Wildcard glob matcher.
// Text arrives on the input channel one byte per beat (text_byte_i, in_valid_i,
// in_stall_o); a zero byte ends the string. Only the ending byte yields a result
// beat on the output channel (matched_o, out_valid_o, out_stall_i).
// The pattern ('?' any byte, '*' any run, backslash escapes) is written through
// the APB port: 64-bit registers at byte addresses 0, 8, 16 and 24 (pattern bytes
// 0-7, 8-15, 16-23, length). Write it only while no beat is in flight; a new
// pattern applies at once, also to a string in progress.
// Throughput: one byte per cycle unless an ending byte is held by a stalled
// result. The active-position update and star closure are a single
// combinational pass between the byte stage register and the position/result
// registers. An accepted byte is captured in the byte stage register and
// evaluated there; an ending byte's result beat is registered when it advances.
// Reset clears the pattern registers, sets only position zero active and drops
// any beat in flight. While the receiver stalls, the pending result holds and
// ordinary bytes keep flowing; a second ending byte waits in the stage register
// and in_stall_o rises until the result is taken.
module wildcard_glob_matcher import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic [7:0]  text_byte_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        matched_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);

  localparam int POS = PATTERN_MAX + 1;

  logic [63:0]    pat_low_q, pat_mid_q, pat_high_q;
  logic [4:0]     pat_len_q;
  logic [191:0]   pat_all;
  reg_idx_e       cfg_idx;
  logic           cfg_we;

  logic           s1_valid_q;
  logic [7:0]     s1_byte_q;
  logic           s1_end, s1_adv, out_free, in_take;
  logic [POS-1:0] active_q, active_d, step_active;
  logic           early_q, early_d;
  wgm_flags_t     flags;
  logic           out_valid_q, out_valid_d, matched_q;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[4:3]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_PAT_LOW:  prdata = pat_low_q;
      REG_PAT_MID:  prdata = pat_mid_q;
      REG_PAT_HIGH: prdata = pat_high_q;
      REG_PAT_LEN:  prdata = {59'd0, pat_len_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_mid_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PAT_LOW:  pat_low_q  <= pwdata;
        REG_PAT_MID:  pat_mid_q  <= pwdata;
        REG_PAT_HIGH: pat_high_q <= pwdata;
        REG_PAT_LEN:  pat_len_q  <= pwdata[4:0];
        default:      ;
      endcase
    end
  end

  assign pat_all = {pat_high_q, pat_mid_q, pat_low_q};

  // Handshake: an ordinary byte never waits on the output side
  assign s1_end      = s1_byte_q == 8'h00;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && (!s1_end || out_free);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // Byte stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= text_byte_i;
    end
  end

  wgm_step #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_step (
    .pat_i       (pat_all[8*PATTERN_MAX-1:0]),
    .pat_len_i   (pat_len_q),
    .active_i    (active_q),
    .early_i     (early_q),
    .text_byte_i (s1_byte_q),
    .active_o    (step_active),
    .flags_o     (flags)
  );

  // Advance the position set; an ending byte restarts it
  always_comb begin
    active_d    = active_q;
    early_d     = early_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_adv) begin
      if (s1_end) begin
        active_d    = POS'(1);
        early_d     = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        active_d = step_active;
        early_d  = flags.early;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= POS'(1);
      early_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      early_q     <= early_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register loads only on an ending byte
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_end) begin
      matched_q <= flags.matched;
    end
  end

  // Checks
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_end) |=> (active_q == POS'(1)) && !early_q)
    else $error("position set not restarted after ending byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_end))
    else $error("input stalled without a blocked result");

  a_early_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_end && early_q) |=> (out_valid_o && matched_o))
    else $error("early accept lost at string end");

endmodule
